### rtl/isl_pkg.sv
`timescale 1ns / 1ps

package isl_pkg;

  localparam int unsigned CapacityDefault = 16;

  localparam int unsigned IndexWidth = 8;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 9;
  localparam int unsigned OpWidth    = 3;
  localparam int unsigned StatWidth  = 2;

  localparam logic [OpWidth-1:0] OP_APPEND    = 3'd0;
  localparam logic [OpWidth-1:0] OP_REMOVE_LAST = 3'd1;
  localparam logic [OpWidth-1:0] OP_INSERT    = 3'd2;
  localparam logic [OpWidth-1:0] OP_REMOVE_AT = 3'd3;
  localparam logic [OpWidth-1:0] OP_READ      = 3'd4;
  localparam logic [OpWidth-1:0] OP_WRITE     = 3'd5;
  localparam logic [OpWidth-1:0] OP_CLEAR     = 3'd6;

  localparam logic [StatWidth-1:0] ST_OK      = 2'd0;
  localparam logic [StatWidth-1:0] ST_INVALID = 2'd1;
  localparam logic [StatWidth-1:0] ST_FULL    = 2'd2;
  localparam logic [StatWidth-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic [OpWidth-1:0]    req_type;
    logic [IndexWidth-1:0] index;
    logic [WordWidth-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] read_value;
    logic [StatWidth-1:0]        status;
    logic [CountWidth-1:0]       count;
  } rsp_t;

endpackage

### rtl/isl_ctrl.sv
`timescale 1ns / 1ps

module isl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output isl_pkg::cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted request did not start execution");

  a_exec_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("executed request produced no result");

  a_exec_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (state_q == S_EXEC) && out_free)
    else $error("result overwritten while still pending");

  a_no_double_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.exec && cmd_o.capture))
    else $error("capture and execute in one cycle");

endmodule

### rtl/isl_dp.sv
`timescale 1ns / 1ps

module isl_dp #(
  parameter int unsigned CAPACITY = isl_pkg::CapacityDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  isl_pkg::cmd_t cmd_i,
  input  isl_pkg::req_t req_i,
  output isl_pkg::rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [isl_pkg::CountWidth-1:0] Cap9 = isl_pkg::CountWidth'(CAPACITY);

  isl_pkg::req_t req_q;
  isl_pkg::rsp_t rsp_q, rsp_d;
  logic [CW-1:0] count_q, count_d;
  logic [isl_pkg::WordWidth-1:0] cells_q [CAPACITY];

  logic [isl_pkg::CountWidth-1:0] n9, idx9;
  logic idx_ok, is_full, is_empty;
  logic do_append, do_insert, do_remove, do_write;
  logic [IW-1:0] idx_sel;

  assign n9       = isl_pkg::CountWidth'(count_q);
  assign idx9     = isl_pkg::CountWidth'(req_q.index);
  assign idx_ok   = idx9 < n9;
  assign is_full  = (n9 == Cap9);
  assign is_empty = (n9 == '0);
  assign idx_sel  = req_q.index[IW-1:0];

  always_comb begin
    count_d   = count_q;
    rsp_d     = rsp_q;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_write  = 1'b0;
    if (cmd_i.exec) begin
      rsp_d.read_value = '0;
      rsp_d.status     = isl_pkg::ST_OK;
      unique case (req_q.req_type)
        isl_pkg::OP_APPEND: begin
          if (is_full) begin
            rsp_d.status = isl_pkg::ST_FULL;
          end else begin
            do_append = 1'b1;
            count_d   = count_q + 1'b1;
          end
        end
        isl_pkg::OP_REMOVE_LAST: begin
          if (is_empty) begin
            rsp_d.status = isl_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        isl_pkg::OP_INSERT: begin
          if (!idx_ok) begin
            rsp_d.status = isl_pkg::ST_INVALID;
          end else if (is_full) begin
            rsp_d.status = isl_pkg::ST_FULL;
          end else begin
            do_insert = 1'b1;
            count_d   = count_q + 1'b1;
          end
        end
        isl_pkg::OP_REMOVE_AT: begin
          if (!idx_ok) begin
            rsp_d.status = isl_pkg::ST_INVALID;
          end else begin
            do_remove = 1'b1;
            count_d   = count_q - 1'b1;
          end
        end
        isl_pkg::OP_READ: begin
          if (!idx_ok) begin
            rsp_d.status     = isl_pkg::ST_INVALID;
            rsp_d.read_value = '1;
          end else begin
            rsp_d.read_value = cells_q[idx_sel];
          end
        end
        isl_pkg::OP_WRITE: begin
          if (!idx_ok) begin
            rsp_d.status = isl_pkg::ST_INVALID;
          end else begin
            do_write = 1'b1;
          end
        end
        isl_pkg::OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
      rsp_d.count = isl_pkg::CountWidth'(count_d);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [isl_pkg::CountWidth-1:0] Pos = isl_pkg::CountWidth'(i);
    logic [isl_pkg::WordWidth-1:0] below, above;
    if (i > 0) begin : g_below
      assign below = cells_q[i-1];
    end else begin : g_no_below
      assign below = req_q.value;
    end
    if (i < CAPACITY - 1) begin : g_above
      assign above = cells_q[i+1];
    end else begin : g_no_above
      assign above = cells_q[i];
    end
    always_ff @(posedge clk_i) begin
      if ((do_append && (Pos == n9)) || ((do_insert || do_write) && (Pos == idx9))) begin
        cells_q[i] <= req_q.value;
      end else if (do_insert && (Pos > idx9) && (Pos <= n9)) begin
        cells_q[i] <= below;
      end else if (do_remove && (Pos >= idx9) && (Pos + 1'b1 < n9)) begin
        cells_q[i] <= above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### rtl/indexed_shift_list_top.sv
`timescale 1ns / 1ps

// Ordered list of signed 32-bit words with a fixed capacity of CAPACITY entries.
// Slave channel s_axis carries one request: append, remove last, insert at index,
// remove at index, read, write or clear. Master channel m_axis returns exactly one
// response per request with the read word, a status code and the count afterwards.
// A request is taken in the idle state and executed in the execute state once the
// output register is free; all entries shift at once and the response is registered.
// A new request is not accepted until the previous one has executed, set by the
// capture/execute sequence of the controller.
// Reset empties the list (count zero); stored words are not cleared and cannot be
// read before they are written.
// While the receiver stalls, the pending response is held in the output register;
// one more request is accepted and held in the execute state, and s_axis_tready
// then stays low until the held response is taken.
module indexed_shift_list_top #(
  parameter int unsigned CAPACITY = isl_pkg::CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // req_type[2:0], index[10:3], value[42:11], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // read_value[31:0], status[33:32], count[42:34], zero fill
);

  isl_pkg::cmd_t cmd;
  isl_pkg::req_t req;
  isl_pkg::rsp_t rsp;

  assign req.req_type = s_axis_tdata[2:0];
  assign req.index    = s_axis_tdata[10:3];
  assign req.value    = s_axis_tdata[42:11];

  assign m_axis_tdata = {5'd0, rsp.count, rsp.status, rsp.read_value};

  isl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  isl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req),
    .rsp_o  (rsp)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Cap = isl_pkg::CapacityDefault;
  localparam logic [isl_pkg::OpWidth-1:0] OP_UNDEFINED = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  isl_pkg::req_t queued_reqs[$];
  isl_pkg::rsp_t predicted_rsps[$];
  isl_pkg::req_t offered_req;
  isl_pkg::req_t next_req;
  isl_pkg::rsp_t seen_rsp;
  isl_pkg::rsp_t want_rsp;

  logic [isl_pkg::WordWidth-1:0] list_words[Cap];
  int unsigned list_len = 0;

  int tx_idle_pct = 17;
  int rx_idle_pct = 55;
  logic rx_hold = 1'b0;
  int unsigned accepted_n = 0;
  int unsigned mismatch_n = 0;

  indexed_shift_list_top #(
    .CAPACITY(Cap)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void run_list_op(input isl_pkg::req_t rq);
    isl_pkg::rsp_t rs;
    logic in_range;
    rs.read_value = '0;
    rs.status = isl_pkg::ST_OK;
    in_range = (rq.index < list_len);
    case (rq.req_type)
      isl_pkg::OP_APPEND: begin
        if (list_len >= Cap) begin
          rs.status = isl_pkg::ST_FULL;
        end else begin
          list_words[list_len] = rq.value;
          list_len++;
        end
      end
      isl_pkg::OP_REMOVE_LAST: begin
        if (list_len == 0) begin
          rs.status = isl_pkg::ST_EMPTY;
        end else begin
          list_len--;
        end
      end
      isl_pkg::OP_INSERT: begin
        if (!in_range) begin
          rs.status = isl_pkg::ST_INVALID;
        end else if (list_len >= Cap) begin
          rs.status = isl_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > rq.index; i--) list_words[i] = list_words[i-1];
          list_words[rq.index] = rq.value;
          list_len++;
        end
      end
      isl_pkg::OP_REMOVE_AT: begin
        if (!in_range) begin
          rs.status = isl_pkg::ST_INVALID;
        end else begin
          for (int i = rq.index; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      isl_pkg::OP_READ: begin
        if (!in_range) begin
          rs.status = isl_pkg::ST_INVALID;
          rs.read_value = '1;
        end else begin
          rs.read_value = list_words[rq.index];
        end
      end
      isl_pkg::OP_WRITE: begin
        if (!in_range) begin
          rs.status = isl_pkg::ST_INVALID;
        end else begin
          list_words[rq.index] = rq.value;
        end
      end
      isl_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    rs.count = list_len[isl_pkg::CountWidth-1:0];
    predicted_rsps.push_back(rs);
  endfunction

  function automatic isl_pkg::req_t mk_req(input logic [isl_pkg::OpWidth-1:0] op,
                                           input int idx,
                                           input logic [isl_pkg::WordWidth-1:0] val);
    isl_pkg::req_t rq;
    rq.req_type = op;
    rq.index = idx[isl_pkg::IndexWidth-1:0];
    rq.value = val;
    return rq;
  endfunction

  function automatic isl_pkg::req_t rand_req(input bit grow);
    logic [isl_pkg::OpWidth-1:0] op;
    logic [isl_pkg::WordWidth-1:0] val;
    int idx;
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 32) op = isl_pkg::OP_APPEND;
      else if (r < 52) op = isl_pkg::OP_INSERT;
      else if (r < 60) op = isl_pkg::OP_REMOVE_LAST;
      else if (r < 70) op = isl_pkg::OP_REMOVE_AT;
      else if (r < 84) op = isl_pkg::OP_READ;
      else if (r < 98) op = isl_pkg::OP_WRITE;
      else op = OP_UNDEFINED;
    end else begin
      if (r < 10) op = isl_pkg::OP_APPEND;
      else if (r < 18) op = isl_pkg::OP_INSERT;
      else if (r < 40) op = isl_pkg::OP_REMOVE_LAST;
      else if (r < 62) op = isl_pkg::OP_REMOVE_AT;
      else if (r < 78) op = isl_pkg::OP_READ;
      else if (r < 92) op = isl_pkg::OP_WRITE;
      else if (r < 97) op = isl_pkg::OP_CLEAR;
      else op = OP_UNDEFINED;
    end
    if ($urandom_range(9) < 8) idx = $urandom_range(0, Cap);
    else idx = $urandom_range(255);
    case ($urandom_range(9))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = 32'hffff_ffff;
      3: val = 32'h0000_0000;
      default: val = $urandom;
    endcase
    return mk_req(op, idx, val);
  endfunction

  task automatic add_random(input int n);
    for (int k = 0; k < n; k++) queued_reqs.push_back(rand_req(((k / 40) % 2) == 0));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_reqs.size() != 0 || s_axis_tvalid || predicted_rsps.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        run_list_op(offered_req);
        accepted_n <= accepted_n + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queued_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_req = queued_reqs.pop_front();
          offered_req <= next_req;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, next_req.value, next_req.index, next_req.req_type};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_rsp.read_value = m_axis_tdata[31:0];
        seen_rsp.status = m_axis_tdata[33:32];
        seen_rsp.count = m_axis_tdata[42:34];
        if (predicted_rsps.size() == 0) begin
          $error("response with no request outstanding: %h", m_axis_tdata);
          mismatch_n++;
        end else begin
          want_rsp = predicted_rsps.pop_front();
          if (seen_rsp.read_value !== want_rsp.read_value) begin
            $error("read_value: expected %0d, got %0d", want_rsp.read_value,
                   seen_rsp.read_value);
            mismatch_n++;
          end
          if (seen_rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, seen_rsp.status);
            mismatch_n++;
          end
          if (seen_rsp.count !== want_rsp.count) begin
            $error("count: expected %0d, got %0d", want_rsp.count, seen_rsp.count);
            mismatch_n++;
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hold off the receiver long enough to back up the request channel
  initial begin
    wait (accepted_n >= 720);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 0, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_REMOVE_LAST, 0, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_INSERT, 0, 32'h1111_1111));
    queued_reqs.push_back(mk_req(isl_pkg::OP_REMOVE_AT, 0, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_WRITE, 0, 32'h2222_2222));
    queued_reqs.push_back(mk_req(OP_UNDEFINED, 255, 32'hffff_ffff));
    queued_reqs.push_back(mk_req(isl_pkg::OP_APPEND, 0, 32'h8000_0000));
    queued_reqs.push_back(mk_req(isl_pkg::OP_APPEND, 255, 32'h7fff_ffff));
    queued_reqs.push_back(mk_req(isl_pkg::OP_APPEND, 0, 32'h0000_0000));
    queued_reqs.push_back(mk_req(isl_pkg::OP_INSERT, 0, 32'hffff_ffff));
    queued_reqs.push_back(mk_req(isl_pkg::OP_INSERT, 3, 32'h1234_5678));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 0, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 3, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 4, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 5, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_REMOVE_AT, 2, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_WRITE, 1, 32'h5a5a_5a5a));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 1, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 255, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_REMOVE_AT, 255, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_WRITE, 4, 32'ha5a5_a5a5));
    queued_reqs.push_back(mk_req(isl_pkg::OP_CLEAR, 0, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_READ, 0, 32'h0));
    queued_reqs.push_back(mk_req(isl_pkg::OP_APPEND, 0, 32'h0000_0001));
    add_random(280);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();
    tx_idle_pct <= 55;
    rx_idle_pct <= 17;
    add_random(280);
    wait_drained();
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    add_random(280);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
